// ===== hdl/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Phase codes, command codes, register indexes and the result beat type.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_A, PH_ST_B,
    PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
    PH_WR_LOW, PH_WR_SET, PH_WR_HIGH,
    PH_AK_LOW, PH_AK_REL, PH_AK_HIGH,
    PH_RD_PRE, PH_RD_LOW, PH_RD_HIGH,
    PH_RA_LOW, PH_RA_SET, PH_RA_HIGH
  } phase_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic REG_HALF    = 1'b0;
  localparam logic REG_QUARTER = 1'b1;

  localparam int unsigned CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] HALF_RESET    = 16'd100;
  localparam logic [CFG_WIDTH-1:0] QUARTER_RESET = 16'd50;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       ready_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_data;
  } result_t;

endpackage

// ===== hdl/i2cbm_core.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master core
// Holds the bus state and timing registers and works out each tick's update.
// ----------------------------------------------------------------------------
module i2cbm_core import i2cbm_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 cmd_valid,
  input  logic [1:0]           opcode,
  input  logic [7:0]           write_data,
  input  logic                 send_ack,
  input  logic                 sda_in,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  output result_t              res
);

  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
  localparam logic [TIMER_WIDTH-1:0] ONE_TICK = TIMER_WIDTH'(1);

  logic [CFG_WIDTH-1:0]   half_period_ticks;
  logic [CFG_WIDTH-1:0]   quarter_period_ticks;
  logic [TIMER_WIDTH-1:0] half_len;
  logic [TIMER_WIDTH-1:0] quarter_len;
  logic [31:0]            half_wide;
  logic [31:0]            quarter_wide;

  phase_t                 phase, phase_next;
  logic [TIMER_WIDTH-1:0] wait_count, wait_count_next;
  logic [2:0]             bit_index, bit_index_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   scl_drive, scl_drive_next;
  logic                   sda_drive, sda_drive_next;
  logic                   ack_flag, ack_flag_next;
  logic                   ack_to_drive, ack_to_drive_next;
  logic [7:0]             last_read, last_read_next;

  logic start_cmd;
  logic step;
  logic entering;
  logic done;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks    <= HALF_RESET;
      quarter_period_ticks <= QUARTER_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HALF:    half_period_ticks    <= cfg_wdata;
        REG_QUARTER: quarter_period_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    half_wide    = {{(32 - CFG_WIDTH){1'b0}}, half_period_ticks};
    quarter_wide = {{(32 - CFG_WIDTH){1'b0}}, quarter_period_ticks};
    if (half_wide > TIMER_MAX) half_len = TIMER_MAX[TIMER_WIDTH-1:0];
    else if (half_period_ticks == '0) half_len = ONE_TICK;
    else half_len = half_wide[TIMER_WIDTH-1:0];
    if (quarter_wide > TIMER_MAX) quarter_len = TIMER_MAX[TIMER_WIDTH-1:0];
    else if (quarter_period_ticks == '0) quarter_len = ONE_TICK;
    else quarter_len = quarter_wide[TIMER_WIDTH-1:0];
  end

  assign start_cmd = (phase == PH_IDLE) && cmd_valid;
  assign step      = (phase != PH_IDLE) && (wait_count <= ONE_TICK);

  always_comb begin
    phase_next = phase;
    if (start_cmd) begin
      case (opcode)
        OP_START: phase_next = PH_ST_A;
        OP_STOP:  phase_next = PH_SP_A;
        OP_WRITE: phase_next = PH_WR_LOW;
        default:  phase_next = sda_drive ? PH_RD_LOW : PH_RD_PRE;
      endcase
    end else if (step) begin
      case (phase)
        PH_ST_A:    phase_next = PH_ST_B;
        PH_SP_A:    phase_next = PH_SP_B;
        PH_SP_B:    phase_next = PH_SP_C;
        PH_SP_C:    phase_next = PH_SP_D;
        PH_WR_LOW:  phase_next = PH_WR_SET;
        PH_WR_SET:  phase_next = PH_WR_HIGH;
        PH_WR_HIGH: phase_next = (bit_index < LAST_BIT) ? PH_WR_LOW : PH_AK_LOW;
        PH_AK_LOW:  phase_next = PH_AK_REL;
        PH_AK_REL:  phase_next = PH_AK_HIGH;
        PH_RD_PRE:  phase_next = PH_RD_LOW;
        PH_RD_LOW:  phase_next = PH_RD_HIGH;
        PH_RD_HIGH: phase_next = (bit_index < LAST_BIT) ? PH_RD_LOW : PH_RA_LOW;
        PH_RA_LOW:  phase_next = PH_RA_SET;
        PH_RA_SET:  phase_next = PH_RA_HIGH;
        default:    phase_next = PH_IDLE;
      endcase
    end
  end

  assign entering = start_cmd || (step && (phase_next != PH_IDLE));
  assign done     = step && (phase_next == PH_IDLE);

  always_comb begin
    wait_count_next   = wait_count;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    scl_drive_next    = scl_drive;
    sda_drive_next    = sda_drive;
    ack_flag_next     = ack_flag;
    ack_to_drive_next = ack_to_drive;
    last_read_next    = last_read;

    if (start_cmd) begin
      bit_index_next = '0;
      if (opcode == OP_WRITE) begin
        shift_byte_next = write_data;
      end else if (opcode == OP_READ) begin
        shift_byte_next   = '0;
        ack_to_drive_next = send_ack;
      end
    end else if (step) begin
      case (phase)
        PH_ST_B: scl_drive_next = 1'b0;
        PH_WR_HIGH: begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          if (bit_index < LAST_BIT) bit_index_next = bit_index + 3'd1;
        end
        PH_AK_HIGH: ack_flag_next = ~sda_in;
        PH_RD_HIGH: begin
          shift_byte_next = {shift_byte[6:0], sda_in};
          if (bit_index < LAST_BIT) bit_index_next = bit_index + 3'd1;
          else last_read_next = {shift_byte[6:0], sda_in};
        end
        default: ;
      endcase
      if (done) wait_count_next = '0;
    end else if (phase != PH_IDLE) begin
      wait_count_next = wait_count - ONE_TICK;
    end

    if (entering) begin
      wait_count_next = quarter_len;
      case (phase_next)
        PH_ST_A: scl_drive_next = 1'b1;
        PH_ST_B: sda_drive_next = 1'b0;
        PH_SP_A: scl_drive_next = 1'b0;
        PH_SP_B: begin
          sda_drive_next  = 1'b0;
          wait_count_next = half_len;
        end
        PH_SP_C: scl_drive_next = 1'b1;
        PH_SP_D: begin
          sda_drive_next  = 1'b1;
          wait_count_next = half_len;
        end
        PH_WR_LOW: scl_drive_next = 1'b0;
        PH_WR_SET: sda_drive_next = (shift_byte_next & MSB_MASK) != 8'h00;
        PH_WR_HIGH: begin
          scl_drive_next  = 1'b1;
          wait_count_next = half_len;
        end
        PH_AK_LOW: scl_drive_next = 1'b0;
        PH_AK_REL: sda_drive_next = 1'b1;
        PH_AK_HIGH: begin
          scl_drive_next  = 1'b1;
          wait_count_next = half_len;
        end
        PH_RD_PRE: scl_drive_next = 1'b0;
        PH_RD_LOW: begin
          scl_drive_next  = 1'b0;
          sda_drive_next  = 1'b1;
          wait_count_next = half_len;
        end
        PH_RD_HIGH: begin
          scl_drive_next  = 1'b1;
          wait_count_next = half_len;
        end
        PH_RA_LOW: scl_drive_next = 1'b0;
        PH_RA_SET: sda_drive_next = ~ack_to_drive_next;
        PH_RA_HIGH: begin
          scl_drive_next  = 1'b1;
          wait_count_next = half_len;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_count   <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      scl_drive    <= 1'b1;
      sda_drive    <= 1'b1;
      ack_flag     <= 1'b0;
      ack_to_drive <= 1'b0;
      last_read    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      wait_count   <= wait_count_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      scl_drive    <= scl_drive_next;
      sda_drive    <= sda_drive_next;
      ack_flag     <= ack_flag_next;
      ack_to_drive <= ack_to_drive_next;
      last_read    <= last_read_next;
    end
  end

  always_comb begin
    res.scl_release = scl_drive_next;
    res.sda_release = sda_drive_next;
    res.ready_res   = (phase_next == PH_IDLE);
    res.done_res    = done;
    res.ack_seen    = ack_flag_next;
    res.read_data   = last_read_next;
  end

  a_wait_loaded: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (wait_count != '0))
    else $error("busy phase with an empty wait counter");

  a_hold_when_idle_tick: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(phase) && $stable(wait_count) && $stable(shift_byte)))
    else $error("state moved without an accepted tick");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> (phase == PH_IDLE))
    else $error("completion did not return to idle");

endmodule

// ===== hdl/i2cbm_skid.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master result buffer
// Output register with a skid stage, so a tick is taken while a result waits.
// ----------------------------------------------------------------------------
module i2cbm_skid import i2cbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  input  result_t push_data,
  output logic    push_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    push;

  assign push       = push_valid && !skid_valid;
  assign push_stall = skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_valid && out_stall) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      main_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (main_valid && out_stall) begin
      if (push) skid_data <= push_data;
    end else if (skid_valid) begin
      main_data <= skid_data;
    end else if (push) begin
      main_data <= push_data;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid stage full while output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> skid_valid && $stable(skid_data))
    else $error("skid stage overwritten");

  a_held_beat: assert property (@(posedge clk) disable iff (rst)
    (main_valid && out_stall) |=> (main_valid && $stable(main_data)))
    else $error("stalled result beat changed");

endmodule

// ===== hdl/i2c_bit_level_master_top.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master
// Each input beat is one timer tick; one result beat leaves per tick and is
// registered in the output buffer. A tick is accepted every cycle while the
// output side keeps up; a two-entry output buffer absorbs one stalled beat.
// Synchronous reset releases both lines, returns to idle and restores the
// half and quarter period registers to 100 and 50 ticks.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_top import i2cbm_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd_valid,
  input  logic [1:0]           opcode,
  input  logic [7:0]           write_data,
  input  logic                 send_ack,
  input  logic                 sda_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 scl_release,
  output logic                 sda_release,
  output logic                 ready_res,
  output logic                 done_res,
  output logic                 ack_seen,
  output logic [7:0]           read_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata
);

  result_t res;
  result_t out_data;
  logic    accept;

  assign accept = in_valid && !in_stall;

  i2cbm_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd_valid  (cmd_valid),
    .opcode     (opcode),
    .write_data (write_data),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .res        (res)
  );

  i2cbm_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_data  (res),
    .push_stall (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign scl_release = out_data.scl_release;
  assign sda_release = out_data.sda_release;
  assign ready_res   = out_data.ready_res;
  assign done_res    = out_data.done_res;
  assign ack_seen    = out_data.ack_seen;
  assign read_data   = out_data.read_data;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master testbench
// Drives timer ticks carrying start, stop, write and read commands with a
// modelled slave on SDA. It predicts the line drives, status and data of every
// result beat and checks each one against the block's output. Both channels
// see random gaps, and the timing registers are swept between runs of traffic,
// the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbm_pkg::*;

  typedef enum logic [1:0] {SLAVE_LOW, SLAVE_HIGH, SLAVE_RANDOM} slave_t;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_TICKS = 400;
  localparam int unsigned TICKS_PER_SETTING = 150;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 cmd_valid;
  logic [1:0]           opcode;
  logic [7:0]           write_data;
  logic                 send_ack;
  logic                 sda_in;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 scl_release;
  logic                 sda_release;
  logic                 ready_res;
  logic                 done_res;
  logic                 ack_seen;
  logic [7:0]           read_data;
  logic                 cfg_wr_en;
  logic                 cfg_index;
  logic [CFG_WIDTH-1:0] cfg_wdata;

  bit          gaps_on = 1'b1;
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned idle_cycles = 0;
  result_t     bus_states_due[$];

  // Predicted state of the master and its timing registers.
  phase_t               ph;
  logic [15:0]          wcnt;
  logic [3:0]           bidx;
  logic [7:0]           shreg;
  logic                 scl_d;
  logic                 sda_d;
  logic                 ackf;
  logic [1:0]           cur_op;
  logic                 ack_drv;
  logic [7:0]           last_rd;
  logic [CFG_WIDTH-1:0] half_cfg;
  logic [CFG_WIDTH-1:0] quarter_cfg;

  i2c_bit_level_master_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd_valid   (cmd_valid),
    .opcode      (opcode),
    .write_data  (write_data),
    .send_ack    (send_ack),
    .sda_in      (sda_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_release (scl_release),
    .sda_release (sda_release),
    .ready_res   (ready_res),
    .done_res    (done_res),
    .ack_seen    (ack_seen),
    .read_data   (read_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] span(input logic [CFG_WIDTH-1:0] r);
    return (r == '0) ? 16'd1 : 16'(r);
  endfunction

  function automatic void reset_bus_model();
    ph = PH_IDLE;
    wcnt = '0;
    bidx = '0;
    shreg = '0;
    scl_d = 1'b1;
    sda_d = 1'b1;
    ackf = 1'b0;
    cur_op = OP_START;
    ack_drv = 1'b0;
    last_rd = '0;
    half_cfg = HALF_RESET;
    quarter_cfg = QUARTER_RESET;
  endfunction

  function automatic void begin_segment(input phase_t p);
    logic [15:0] w;
    w = span(quarter_cfg);
    ph = p;
    case (p)
      PH_ST_A: scl_d = 1'b1;
      PH_ST_B: sda_d = 1'b0;
      PH_SP_A: scl_d = 1'b0;
      PH_SP_B: begin
        sda_d = 1'b0;
        w = span(half_cfg);
      end
      PH_SP_C: scl_d = 1'b1;
      PH_SP_D: begin
        sda_d = 1'b1;
        w = span(half_cfg);
      end
      PH_WR_LOW: scl_d = 1'b0;
      PH_WR_SET: sda_d = ((shreg & MSB_MASK) != 8'h00);
      PH_WR_HIGH, PH_AK_HIGH, PH_RD_HIGH, PH_RA_HIGH: begin
        scl_d = 1'b1;
        w = span(half_cfg);
      end
      PH_AK_LOW, PH_RD_PRE, PH_RA_LOW: scl_d = 1'b0;
      PH_AK_REL: sda_d = 1'b1;
      PH_RD_LOW: begin
        scl_d = 1'b0;
        sda_d = 1'b1;
        w = span(half_cfg);
      end
      PH_RA_SET: sda_d = !ack_drv;
      default: begin
        ph = PH_IDLE;
        w = '0;
      end
    endcase
    wcnt = w;
  endfunction

  // Acts at the end of a segment's wait and returns 1 when the command completes.
  function automatic logic end_segment(input logic sda);
    logic fin;
    fin = 1'b0;
    case (ph)
      PH_ST_A:   begin_segment(PH_ST_B);
      PH_ST_B: begin
        scl_d = 1'b0;
        fin = 1'b1;
      end
      PH_SP_A:   begin_segment(PH_SP_B);
      PH_SP_B:   begin_segment(PH_SP_C);
      PH_SP_C:   begin_segment(PH_SP_D);
      PH_WR_LOW: begin_segment(PH_WR_SET);
      PH_WR_SET: begin_segment(PH_WR_HIGH);
      PH_WR_HIGH: begin
        shreg = shreg << 1;
        if (bidx < LAST_BIT) begin
          bidx = bidx + 4'd1;
          begin_segment(PH_WR_LOW);
        end else begin
          begin_segment(PH_AK_LOW);
        end
      end
      PH_AK_LOW: begin_segment(PH_AK_REL);
      PH_AK_REL: begin_segment(PH_AK_HIGH);
      PH_AK_HIGH: begin
        ackf = !sda;
        fin = 1'b1;
      end
      PH_RD_PRE: begin_segment(PH_RD_LOW);
      PH_RD_LOW: begin_segment(PH_RD_HIGH);
      PH_RD_HIGH: begin
        shreg = {shreg[6:0], sda};
        if (bidx < LAST_BIT) begin
          bidx = bidx + 4'd1;
          begin_segment(PH_RD_LOW);
        end else begin
          last_rd = shreg;
          begin_segment(PH_RA_LOW);
        end
      end
      PH_RA_LOW: begin_segment(PH_RA_SET);
      PH_RA_SET: begin_segment(PH_RA_HIGH);
      default:   fin = 1'b1;
    endcase
    if (fin) begin
      ph = PH_IDLE;
      wcnt = '0;
    end
    return fin;
  endfunction

  function automatic result_t advance_bus_tick(input logic cv, input logic [1:0] op,
                                               input logic [7:0] wd, input logic sack,
                                               input logic sda);
    result_t r;
    logic    done;
    done = 1'b0;
    if (ph == PH_IDLE) begin
      if (cv) begin
        cur_op = op;
        bidx = '0;
        case (op)
          OP_START: begin_segment(PH_ST_A);
          OP_STOP:  begin_segment(PH_SP_A);
          OP_WRITE: begin
            shreg = wd;
            begin_segment(PH_WR_LOW);
          end
          default: begin
            shreg = '0;
            ack_drv = sack;
            begin_segment(sda_d ? PH_RD_LOW : PH_RD_PRE);
          end
        endcase
      end
    end else if (wcnt > 16'd1) begin
      wcnt = wcnt - 16'd1;
    end else begin
      done = end_segment(sda);
    end
    r.scl_release = scl_d;
    r.sda_release = sda_d;
    r.ready_res = (ph == PH_IDLE);
    r.done_res = done;
    r.ack_seen = ackf;
    r.read_data = last_rd;
    return r;
  endfunction

  function automatic logic slave_bit(input slave_t s);
    case (s)
      SLAVE_LOW:  return 1'b0;
      SLAVE_HIGH: return 1'b1;
      default:    return 1'($urandom_range(1));
    endcase
  endfunction

  task automatic send_tick(input logic cv, input logic [1:0] op, input logic [7:0] wd,
                           input logic sack, input logic sda);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd_valid = cv;
    opcode = op;
    write_data = wd;
    send_ack = sack;
    sda_in = sda;
    do @(posedge clk); while (in_stall);
    bus_states_due.push_back(advance_bus_tick(cv, op, wd, sack, sda));
    ticks_sent++;
  endtask

  task automatic idle_ticks(input int unsigned n);
    repeat (n) begin
      send_tick(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // Offers a command on an idle master and ticks on until it has finished.
  task automatic run_command(input logic [1:0] op, input logic [7:0] data, input logic ack,
                             input slave_t s, input bit noisy);
    send_tick(1'b1, op, data, ack, slave_bit(s));
    while (ph != PH_IDLE) begin
      send_tick(noisy ? 1'($urandom_range(1)) : 1'b0, 2'($urandom_range(3)),
                8'($urandom_range(255)), 1'($urandom_range(1)), slave_bit(s));
    end
  endtask

  task automatic run_random_command(input logic [1:0] op);
    run_command(op, 8'($urandom_range(255)), 1'($urandom_range(1)),
                slave_t'($urandom_range(2)), 1'($urandom_range(1)));
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (bus_states_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_WIDTH-1:0] d);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    @(posedge clk);
    if (idx == REG_HALF) begin
      half_cfg = d;
    end else begin
      quarter_cfg = d;
    end
  endtask

  task automatic set_timing(input logic [CFG_WIDTH-1:0] half, input logic [CFG_WIDTH-1:0] quarter);
    settle_block();
    write_reg(REG_HALF, half);
    write_reg(REG_QUARTER, quarter);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic test_reset_timing();
    idle_ticks(3);
    run_random_command(OP_START);
    run_command(OP_STOP, 8'h00, 1'b0, SLAVE_RANDOM, 1'b1);
  endtask

  task automatic test_directed_commands();
    set_timing(16'd1, 16'd1);
    run_command(OP_START, 8'h00, 1'b0, SLAVE_RANDOM, 1'b0);
    run_command(OP_WRITE, 8'hFF, 1'b0, SLAVE_LOW, 1'b0);
    run_command(OP_WRITE, 8'h00, 1'b1, SLAVE_HIGH, 1'b1);
    run_command(OP_READ, 8'h00, 1'b1, SLAVE_HIGH, 1'b0);
    // SDA is still held low by the acknowledge, so this read needs the prelude.
    run_command(OP_READ, 8'hFF, 1'b0, SLAVE_LOW, 1'b1);
    run_command(OP_STOP, 8'h00, 1'b0, SLAVE_RANDOM, 1'b0);
    run_command(OP_START, 8'h00, 1'b0, SLAVE_RANDOM, 1'b1);
    run_command(OP_READ, 8'h00, 1'b1, SLAVE_RANDOM, 1'b0);
    run_command(OP_STOP, 8'h00, 1'b0, SLAVE_RANDOM, 1'b1);
    idle_ticks(2);
  endtask

  task automatic test_zero_periods();
    set_timing(16'd0, 16'd0);
    run_random_command(OP_START);
    run_random_command(OP_WRITE);
    run_random_command(OP_READ);
    run_random_command(OP_STOP);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned seg_first;
    int unsigned k;
    int unsigned nbytes;
    first = ticks_sent;
    k = 0;
    while (ticks_sent - first < RANDOM_TICKS) begin
      set_timing(($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 3)),
                 ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
      gaps_on = (k != 2);
      seg_first = ticks_sent;
      while (ticks_sent - seg_first < TICKS_PER_SETTING) begin
        if ($urandom_range(99) < 80) begin
          run_random_command(OP_START);
          nbytes = $urandom_range(1, 3);
          repeat (nbytes) run_random_command($urandom_range(1) ? OP_WRITE : OP_READ);
          run_random_command(OP_STOP);
        end else begin
          run_random_command(2'($urandom_range(3)));
        end
        idle_ticks($urandom_range(3));
      end
      k++;
    end
    gaps_on = 1'b1;
  endtask

  // A start uses only quarter-period waits, so the largest half period can be
  // loaded without a long run of ticks.
  task automatic test_longest_periods();
    gaps_on = 1'b0;
    set_timing(16'hFFFF, 16'd1);
    run_random_command(OP_START);
    gaps_on = 1'b1;
  endtask

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 21);
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bus_states_due.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        want = bus_states_due.pop_front();
        check_field("scl_release", 8'(want.scl_release), 8'(scl_release));
        check_field("sda_release", 8'(want.sda_release), 8'(sda_release));
        check_field("ready_res", 8'(want.ready_res), 8'(ready_res));
        check_field("done_res", 8'(want.done_res), 8'(done_res));
        check_field("ack_seen", 8'(want.ack_seen), 8'(ack_seen));
        check_field("read_data", want.read_data, read_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd_valid = 1'b0;
    opcode = OP_START;
    write_data = '0;
    send_ack = 1'b0;
    sda_in = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_HALF;
    cfg_wdata = '0;
    reset_bus_model();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_reset_timing();
    test_directed_commands();
    test_zero_periods();
    test_random_traffic();
    test_longest_periods();

    settle_block();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
